// ===== rtl/scsa_pkg.sv =====
// shared types and codes for the sparse column accumulate store
// no dependencies

package scsa_pkg;

    // command codes
    localparam logic [2:0] CMD_ACCUM   = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_RESERVE = 3'd2;
    localparam logic [2:0] CMD_ZERO    = 3'd3;
    localparam logic [2:0] CMD_SCALE   = 3'd4;
    localparam logic [2:0] CMD_CLEAR   = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // datapath strobes driven by the controller
    typedef struct packed {
        logic load;
        logic fill_rd;
        logic walk_sel;
        logic search_init;
        logic rd_mid;
        logic step;
        logic rd_lo;
        logic probe;
        logic shift_init;
        logic shift_rd;
        logic shift_wr;
        logic ins_wr;
        logic acc_wr;
        logic res_entry;
        logic set_oor;
        logic set_full;
        logic walk_init;
        logic ent_init;
        logic ent_rd;
        logic mul;
        logic ent_wr;
        logic col_next;
        logic clr_wr;
    } scsa_cmd_t;

    // datapath conditions seen by the controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       in_range;
        logic       search_more;
        logic       hit;
        logic       full;
        logic       shift_more;
        logic       ent_more;
        logic       col_more;
        logic       clr_last;
    } scsa_stat_t;

endpackage

// ===== rtl/scsa_dp.sv =====
// datapath: column stores, search and shift registers, accumulate and scale arithmetic
// depends on scsa_pkg

module scsa_dp
    import scsa_pkg::*;
#(
    parameter int MAX_COLS    = 256,
    parameter int MAX_PER_COL = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [8:0]         cfg_wdata,
    input  logic [2:0]         command,
    input  logic [7:0]         row,
    input  logic [7:0]         col,
    input  logic signed [31:0] value,
    input  scsa_cmd_t          ctl,
    output scsa_stat_t         stat,
    output logic signed [31:0] result_value,
    output logic [4:0]         slot,
    output logic               found,
    output logic [1:0]         status
);

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SLOT_W = $clog2(MAX_PER_COL);
    localparam int FILL_W = $clog2(MAX_PER_COL + 1);
    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int NW     = (CNT_W > 9) ? CNT_W : 9;
    localparam int ADDR_W = COL_W + SLOT_W;
    localparam int DEPTH  = MAX_COLS * (2 ** SLOT_W);

    // storage
    logic [7:0]        row_mem  [DEPTH];
    logic [31:0]       val_mem  [DEPTH];
    logic [FILL_W-1:0] fill_mem [MAX_COLS];

    logic [8:0]         asz_reg;
    logic [2:0]         cmd_reg;
    logic [7:0]         row_reg;
    logic [7:0]         col_reg;
    logic signed [31:0] vin_reg;
    logic [FILL_W-1:0]  lo_reg, hi_reg, k_reg, fill_reg;
    logic               hit_reg;
    logic signed [31:0] val_reg;
    logic signed [63:0] prod_reg;
    logic [CNT_W-1:0]   wc_reg;
    logic [7:0]         rd_row_q;
    logic signed [31:0] rd_val_q;
    logic [FILL_W-1:0]  fill_q;
    logic signed [31:0] res_val_reg;
    logic [4:0]         res_slot_reg;
    logic               res_found_reg;
    logic [1:0]         res_status_reg;

    logic [COL_W-1:0]   col_idx, wc_idx, fill_addr;
    logic [FILL_W:0]    mid_sum;
    logic [FILL_W-1:0]  mid, km1;
    logic [SLOT_W+4:0]  lo_ext;
    logic [4:0]         lo_slot;
    logic [NW-1:0]      asz_ext, eff_n;
    logic [ADDR_W-1:0]  rd_addr, lo_addr;
    logic               rd_en;
    logic signed [32:0] sum;
    logic signed [31:0] sum_sat;
    logic               sum_ovf;
    logic signed [63:0] rnd, q;
    logic signed [31:0] scl_sat;
    logic               scl_ovf;

    assign col_idx = COL_W'(col_reg);
    assign wc_idx  = wc_reg[COL_W-1:0];
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[FILL_W:1];
    assign km1     = k_reg - 1'b1;
    assign lo_ext  = {5'd0, lo_reg[SLOT_W-1:0]};
    assign lo_slot = lo_ext[4:0];
    assign lo_addr = {col_idx, lo_reg[SLOT_W-1:0]};

    // effective size is min(active_size, MAX_COLS)
    assign asz_ext = NW'(asz_reg);
    assign eff_n   = (asz_ext > NW'(MAX_COLS)) ? NW'(MAX_COLS) : asz_ext;

    // condition flags
    assign stat.cmd         = cmd_reg;
    assign stat.in_range    = (NW'(row_reg) < eff_n) && (NW'(col_reg) < eff_n);
    assign stat.search_more = lo_reg < hi_reg;
    assign stat.hit         = hit_reg;
    assign stat.full        = fill_reg == FILL_W'(MAX_PER_COL);
    assign stat.shift_more  = k_reg > lo_reg;
    assign stat.ent_more    = k_reg < fill_reg;
    assign stat.col_more    = NW'(wc_reg) < eff_n;
    assign stat.clr_last    = wc_reg == CNT_W'(MAX_COLS - 1);

    // saturating accumulate
    assign sum     = {val_reg[31], val_reg} + {vin_reg[31], vin_reg};
    assign sum_ovf = sum[32] != sum[31];
    assign sum_sat = sum_ovf ? (sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : sum[31:0];

    // q16 rounding of the registered product, ties up, then clamp
    assign rnd     = prod_reg + 64'sd32768;
    assign q       = rnd >>> 16;
    assign scl_ovf = (q > 64'sh000000007FFFFFFF) || (q < -64'sh0000000080000000);
    assign scl_sat = (q > 64'sh000000007FFFFFFF) ? 32'sh7FFFFFFF :
                     (q < -64'sh0000000080000000) ? 32'sh80000000 : q[31:0];

    // store read address
    always_comb
    begin
        rd_addr = {col_idx, mid[SLOT_W-1:0]};
        if (ctl.rd_lo)
        begin
            rd_addr = lo_addr;
        end
        else if (ctl.shift_rd)
        begin
            rd_addr = {col_idx, km1[SLOT_W-1:0]};
        end
        else if (ctl.ent_rd)
        begin
            rd_addr = {wc_idx, k_reg[SLOT_W-1:0]};
        end
    end

    assign rd_en     = ctl.rd_mid | ctl.rd_lo | ctl.shift_rd | ctl.ent_rd;
    assign fill_addr = ctl.walk_sel ? wc_idx : col_idx;

    // column store ports
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_q <= row_mem[rd_addr];
            rd_val_q <= val_mem[rd_addr];
        end
        if (ctl.shift_wr)
        begin
            row_mem[{col_idx, k_reg[SLOT_W-1:0]}] <= rd_row_q;
            val_mem[{col_idx, k_reg[SLOT_W-1:0]}] <= rd_val_q;
        end
        else if (ctl.ins_wr)
        begin
            row_mem[lo_addr] <= row_reg;
            val_mem[lo_addr] <= 32'sd0;
        end
        else if (ctl.acc_wr)
        begin
            val_mem[lo_addr] <= sum_sat;
        end
        else if (ctl.ent_wr)
        begin
            val_mem[{wc_idx, k_reg[SLOT_W-1:0]}] <= (cmd_reg == CMD_ZERO) ? 32'sd0 : scl_sat;
        end
    end

    // column fill memory
    always_ff @(posedge clk)
    begin
        if (ctl.fill_rd)
        begin
            fill_q <= fill_mem[fill_addr];
        end
        if (ctl.clr_wr)
        begin
            fill_mem[wc_idx] <= '0;
        end
        else if (ctl.ins_wr)
        begin
            fill_mem[col_idx] <= fill_reg + 1'b1;
        end
    end

    // config register and walk counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asz_reg <= 9'd256;
            wc_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                asz_reg <= cfg_wdata;
            end
            if (ctl.walk_init)
            begin
                wc_reg <= '0;
            end
            else if (ctl.col_next || ctl.clr_wr)
            begin
                wc_reg <= wc_reg + 1'b1;
            end
        end
    end

    // item, search and result registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg        <= command;
            row_reg        <= row;
            col_reg        <= col;
            vin_reg        <= value;
            res_val_reg    <= 32'sd0;
            res_slot_reg   <= 5'd0;
            res_found_reg  <= 1'b0;
            res_status_reg <= ST_OK;
        end
        if (ctl.search_init)
        begin
            lo_reg   <= '0;
            hi_reg   <= fill_q;
            fill_reg <= fill_q;
        end
        if (ctl.step)
        begin
            if (rd_row_q < row_reg)
            begin
                lo_reg <= mid + 1'b1;
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (ctl.probe)
        begin
            hit_reg       <= (lo_reg < fill_reg) && (rd_row_q == row_reg);
            res_found_reg <= (lo_reg < fill_reg) && (rd_row_q == row_reg);
            val_reg       <= rd_val_q;
        end
        if (ctl.shift_init)
        begin
            k_reg <= fill_reg;
        end
        else if (ctl.shift_wr)
        begin
            k_reg <= km1;
        end
        else if (ctl.ent_init)
        begin
            k_reg    <= '0;
            fill_reg <= fill_q;
        end
        else if (ctl.ent_wr)
        begin
            k_reg <= k_reg + 1'b1;
        end
        if (ctl.ins_wr)
        begin
            val_reg <= 32'sd0;
        end
        if (ctl.mul)
        begin
            prod_reg <= rd_val_q * vin_reg;
        end
        if (ctl.res_entry)
        begin
            res_val_reg  <= val_reg;
            res_slot_reg <= lo_slot;
        end
        if (ctl.acc_wr)
        begin
            res_val_reg    <= sum_sat;
            res_slot_reg   <= lo_slot;
            res_status_reg <= sum_ovf ? ST_SAT : ST_OK;
        end
        if (ctl.set_oor)
        begin
            res_status_reg <= ST_RANGE;
        end
        if (ctl.set_full)
        begin
            res_status_reg <= ST_FULL;
        end
        if (ctl.ent_wr && cmd_reg == CMD_SCALE && scl_ovf)
        begin
            res_status_reg <= ST_SAT;
        end
    end

    assign result_value = res_val_reg;
    assign slot         = res_slot_reg;
    assign found        = res_found_reg;
    assign status       = res_status_reg;

endmodule

// ===== rtl/scsa_ctrl.sv =====
// controller: sequences search, insert shift, bulk walks and clearing passes
// depends on scsa_pkg

module scsa_ctrl
    import scsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  scsa_stat_t stat,
    output scsa_cmd_t  ctl
);

    localparam logic [4:0] S_CLR_RST = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_RANGE   = 5'd2;
    localparam logic [4:0] S_SINIT   = 5'd3;
    localparam logic [4:0] S_SCHK    = 5'd4;
    localparam logic [4:0] S_SCMP    = 5'd5;
    localparam logic [4:0] S_PROBE   = 5'd6;
    localparam logic [4:0] S_DECIDE  = 5'd7;
    localparam logic [4:0] S_SHCHK   = 5'd8;
    localparam logic [4:0] S_SHWR    = 5'd9;
    localparam logic [4:0] S_INSD    = 5'd10;
    localparam logic [4:0] S_ACC     = 5'd11;
    localparam logic [4:0] S_WCOL    = 5'd12;
    localparam logic [4:0] S_WFILL   = 5'd13;
    localparam logic [4:0] S_ECHK    = 5'd14;
    localparam logic [4:0] S_EMUL    = 5'd15;
    localparam logic [4:0] S_EWR     = 5'd16;
    localparam logic [4:0] S_CLR_CMD = 5'd17;
    localparam logic [4:0] S_DONE    = 5'd18;

    logic [4:0] state_reg, state_next;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_DONE;

    // next state and strobes
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_CLR_RST:
            begin
                ctl.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    ctl.walk_init = 1'b1;
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                // decode the latched command
                if (stat.cmd == CMD_ACCUM || stat.cmd == CMD_READ ||
                    stat.cmd == CMD_RESERVE)
                begin
                    if (stat.in_range)
                    begin
                        ctl.fill_rd = 1'b1;
                        state_next = S_SINIT;
                    end
                    else
                    begin
                        ctl.set_oor = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else if (stat.cmd == CMD_ZERO || stat.cmd == CMD_SCALE)
                begin
                    state_next = S_WCOL;
                end
                else if (stat.cmd == CMD_CLEAR)
                begin
                    state_next = S_CLR_CMD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SINIT:
            begin
                ctl.search_init = 1'b1;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (stat.search_more)
                begin
                    ctl.rd_mid = 1'b1;
                    state_next = S_SCMP;
                end
                else
                begin
                    ctl.rd_lo = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_SCMP:
            begin
                ctl.step = 1'b1;
                state_next = S_SCHK;
            end
            S_PROBE:
            begin
                ctl.probe = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (stat.cmd == CMD_READ)
                begin
                    ctl.res_entry = stat.hit;
                end
                else if (!stat.hit && stat.full)
                begin
                    ctl.set_full = 1'b1;
                end
                else if (!stat.hit)
                begin
                    ctl.shift_init = 1'b1;
                    state_next = S_SHCHK;
                end
                else if (stat.cmd == CMD_ACCUM)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    ctl.res_entry = 1'b1;
                end
            end
            S_SHCHK:
            begin
                if (stat.shift_more)
                begin
                    ctl.shift_rd = 1'b1;
                    state_next = S_SHWR;
                end
                else
                begin
                    ctl.ins_wr = 1'b1;
                    state_next = S_INSD;
                end
            end
            S_SHWR:
            begin
                ctl.shift_wr = 1'b1;
                state_next = S_SHCHK;
            end
            S_INSD:
            begin
                if (stat.cmd == CMD_ACCUM)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    ctl.res_entry = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_ACC:
            begin
                ctl.acc_wr = 1'b1;
                state_next = S_DONE;
            end
            S_WCOL:
            begin
                ctl.walk_sel = 1'b1;
                if (stat.col_more)
                begin
                    ctl.fill_rd = 1'b1;
                    state_next = S_WFILL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WFILL:
            begin
                ctl.ent_init = 1'b1;
                state_next = S_ECHK;
            end
            S_ECHK:
            begin
                if (stat.ent_more)
                begin
                    ctl.ent_rd = 1'b1;
                    state_next = S_EMUL;
                end
                else
                begin
                    ctl.col_next = 1'b1;
                    state_next = S_WCOL;
                end
            end
            S_EMUL:
            begin
                ctl.mul = 1'b1;
                state_next = S_EWR;
            end
            S_EWR:
            begin
                ctl.ent_wr = 1'b1;
                state_next = S_ECHK;
            end
            S_CLR_CMD:
            begin
                ctl.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/sparse_column_accumulate_store_core.sv =====
// Sparse column store: each column holds a row-sorted list of Q16.16 values in a
// single-port-read store; one command word in, one result word out. After reset a
// clearing pass over all MAX_COLS column fills runs with in_ready low. Each word
// first passes a decode state; access commands then run the binary search (one
// store read per step), on an insert shift each later entry up (read, write back)
// and write the new entry, and on an accumulate do the saturating write. Zero and
// scale visit each column in the active size and each entry in it (read, multiply,
// write back), then make a final column check. Clear resets all MAX_COLS column
// fills, one a cycle. Unknown codes end after decode; results wait for out_ready.
// depends on scsa_pkg, scsa_ctrl, scsa_dp

module sparse_column_accumulate_store_core
    import scsa_pkg::*;
#(
    parameter int MAX_COLS    = 256,
    parameter int MAX_PER_COL = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [8:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic [7:0]         row,
    input  logic [7:0]         col,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result_value,
    output logic [4:0]         slot,
    output logic               found,
    output logic [1:0]         status
);

    scsa_cmd_t  ctl;
    scsa_stat_t stat;

    // sequencer
    scsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // stores and arithmetic
    scsa_dp #(
        .MAX_COLS    (MAX_COLS),
        .MAX_PER_COL (MAX_PER_COL)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .command      (command),
        .row          (row),
        .col          (col),
        .value        (value),
        .ctl          (ctl),
        .stat         (stat),
        .result_value (result_value),
        .slot         (slot),
        .found        (found),
        .status       (status)
    );

endmodule

// ===== rtl/scsa_checker.sv =====
// port-level checks for the sparse column store core, attached by bind
// depends on scsa_pkg and sparse_column_accumulate_store_core

module scsa_checker
    import scsa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_value,
    input logic [4:0]  slot,
    input logic        found,
    input logic [1:0]  status
);

    // one word in flight: never ready for input while a result is shown
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
        else $error("result word changed while stalled");

    // an out of range access reports nothing else
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_RANGE |-> result_value == 32'd0 && slot == 5'd0 && !found)
        else $error("out of range result carries data");

    // a full column means the entry was absent
    a_full_absent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> !found && result_value == 32'd0)
        else $error("column full with entry found");

    // no result word is shown directly after a word is accepted
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");

endmodule

bind sparse_column_accumulate_store_core scsa_checker u_scsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .slot         (slot),
    .found        (found),
    .status       (status)
);

// ===== tb/sv/sparse_column_accumulate_store_core_tb.sv =====
// self-checking testbench for the sparse column accumulate store core
// predicts every result word in a behavioral column store and compares field by field
// depends on scsa_pkg and sparse_column_accumulate_store_core
`timescale 1ns / 100ps

module sparse_column_accumulate_store_core_tb;
    import scsa_pkg::*;

    localparam int NCOLS = 256;
    localparam int PER_COL = 32;
    localparam int STALL_LIMIT = 200000;
    localparam logic [2:0] CMD_UNDEF_A = 3'd6;
    localparam logic [2:0] CMD_UNDEF_B = 3'd7;

    typedef struct {
        logic signed [31:0] res;
        logic [4:0]         pos;
        logic               hit;
        logic [1:0]         st;
    } result_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [8:0]         cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         command = '0;
    logic [7:0]         row = '0;
    logic [7:0]         col = '0;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] result_value;
    logic [4:0]         slot;
    logic               found;
    logic [1:0]         status;

    // behavioral copy of the store
    logic [7:0]         row_list [NCOLS][PER_COL];
    logic signed [31:0] val_list [NCOLS][PER_COL];
    int                 col_fill [NCOLS];
    int                 size_reg;

    result_word_t pending_results[$];
    int  mismatches = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    int  idle_cycles = 0;
    bit  hold_req = 0;
    bit  no_gaps = 0;

    sparse_column_accumulate_store_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .command(command), .row(row),
        .col(col), .value(value), .out_valid(out_valid), .out_ready(out_ready),
        .result_value(result_value), .slot(slot), .found(found), .status(status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic signed [31:0] clamp_q16(longint x, ref bit sat);
        if (x > 64'sd2147483647)
        begin
            sat = 1;
            return 32'sh7fffffff;
        end
        if (x < -64'sd2147483648)
        begin
            sat = 1;
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // expected result of one command word, updating the behavioral store
    function automatic result_word_t store_update(logic [2:0] c, logic [7:0] r,
                                                  logic [7:0] k, logic signed [31:0] v);
        result_word_t o;
        int  n, lo, hi, mid, j;
        bit  hit, sat;
        o = '{0, 0, 0, ST_OK};
        sat = 0;
        n = (size_reg > NCOLS) ? NCOLS : size_reg;
        if (c == CMD_ACCUM || c == CMD_READ || c == CMD_RESERVE)
        begin
            if (r >= n || k >= n)
                o.st = ST_RANGE;
            else
            begin
                lo = 0;
                hi = col_fill[k];
                while (lo < hi)
                begin
                    mid = (lo + hi) / 2;
                    if (row_list[k][mid] < r) lo = mid + 1; else hi = mid;
                end
                hit = (lo < col_fill[k]) && (row_list[k][lo] == r);
                o.hit = hit;
                if (c == CMD_READ)
                begin
                    if (hit)
                    begin
                        o.res = val_list[k][lo];
                        o.pos = lo[4:0];
                    end
                end
                else if (!hit && col_fill[k] >= PER_COL)
                    o.st = ST_FULL;
                else
                begin
                    if (!hit)
                    begin
                        for (j = col_fill[k]; j > lo; j--)
                        begin
                            row_list[k][j] = row_list[k][j-1];
                            val_list[k][j] = val_list[k][j-1];
                        end
                        row_list[k][lo] = r;
                        val_list[k][lo] = 0;
                        col_fill[k]++;
                    end
                    o.pos = lo[4:0];
                    if (c == CMD_ACCUM)
                    begin
                        val_list[k][lo] = clamp_q16(longint'(val_list[k][lo]) + longint'(v), sat);
                        if (sat) o.st = ST_SAT;
                    end
                    o.res = val_list[k][lo];
                end
            end
        end
        else if (c == CMD_ZERO || c == CMD_SCALE)
        begin
            for (int cc = 0; cc < n; cc++)
                for (int e = 0; e < col_fill[cc]; e++)
                    if (c == CMD_ZERO)
                        val_list[cc][e] = 0;
                    else
                        val_list[cc][e] = clamp_q16(
                            (longint'(val_list[cc][e]) * longint'(v) + 32768) >>> 16, sat);
            if (sat) o.st = ST_SAT;
        end
        else if (c == CMD_CLEAR)
        begin
            for (int cc = 0; cc < NCOLS; cc++) col_fill[cc] = 0;
        end
        return o;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (no_gaps || p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one command word and record its expected result once accepted
    task automatic send_word(logic [2:0] c, logic [7:0] r, logic [7:0] k,
                             logic signed [31:0] v);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= c;
        row      <= r;
        col      <= k;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(store_update(c, r, k, v));
        words_sent++;
    endtask

    // wait for the store to drain, then write the size register
    task automatic write_size(logic [8:0] s);
        @(posedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        size_reg = s;
    endtask

    // extremes of the fields, every command, unknown codes, saturation
    task automatic test_directed();
        send_word(CMD_READ, 8'd0, 8'd0, 0);
        send_word(CMD_ACCUM, 8'd255, 8'd255, 32'sh7fffffff);
        send_word(CMD_ACCUM, 8'd255, 8'd255, 32'sh00000001);
        send_word(CMD_ACCUM, 8'd0, 8'd255, 32'sh80000000);
        send_word(CMD_ACCUM, 8'd0, 8'd255, 32'sh80000000);
        send_word(CMD_RESERVE, 8'd7, 8'd0, 32'sh12345678);
        send_word(CMD_ACCUM, 8'd3, 8'd0, 32'sh00018000);
        send_word(CMD_RESERVE, 8'd3, 8'd0, 0);
        send_word(CMD_READ, 8'd7, 8'd0, 0);
        send_word(CMD_READ, 8'd3, 8'd0, 0);
        send_word(CMD_READ, 8'd5, 8'd0, 0);
        send_word(CMD_SCALE, 8'd0, 8'd0, 32'sh00020000);
        send_word(CMD_SCALE, 8'd0, 8'd0, 32'shffff0000);
        send_word(CMD_SCALE, 8'd0, 8'd0, 32'sh00008000);
        send_word(CMD_READ, 8'd3, 8'd0, 0);
        send_word(CMD_ZERO, 8'd9, 8'd9, 32'sh5a5a5a5a);
        send_word(CMD_READ, 8'd255, 8'd255, 0);
        send_word(CMD_UNDEF_A, 8'd255, 8'd255, 32'shffffffff);
        send_word(CMD_UNDEF_B, 8'd1, 8'd1, 32'sh00010000);
        send_word(CMD_CLEAR, 8'd0, 8'd0, 0);
        send_word(CMD_READ, 8'd3, 8'd0, 0);
    endtask

    // out-of-range indexes, including the zero and oversized register values
    task automatic test_range();
        write_size(9'd0);
        send_word(CMD_ACCUM, 8'd0, 8'd0, 32'sh00010000);
        send_word(CMD_READ, 8'd0, 8'd0, 0);
        write_size(9'd4);
        send_word(CMD_RESERVE, 8'd4, 8'd0, 0);
        send_word(CMD_ACCUM, 8'd0, 8'd4, 32'sh00010000);
        send_word(CMD_ACCUM, 8'd3, 8'd3, 32'sh00010000);
        write_size(9'd511);
        send_word(CMD_READ, 8'd3, 8'd3, 0);
        send_word(CMD_ACCUM, 8'd255, 8'd254, 32'sh00000100);
    endtask

    // fill one column to capacity, then ask for one more entry
    task automatic test_column_full();
        write_size(9'd256);
        for (int i = 0; i < PER_COL; i++)
            send_word(CMD_RESERVE, 8'(PER_COL - 1 - i) * 8'd2, 8'd17, 0);
        send_word(CMD_ACCUM, 8'd1, 8'd17, 32'sh00010000);
        send_word(CMD_RESERVE, 8'd200, 8'd17, 0);
        send_word(CMD_ACCUM, 8'd62, 8'd17, 32'sh00010000);
        send_word(CMD_CLEAR, 8'd0, 8'd0, 0);
    endtask

    // receiver stops for a long stretch while words keep coming
    task automatic test_backpressure();
        hold_req = 1;
        no_gaps = 1;
        for (int i = 0; i < 12; i++)
            send_word(CMD_ACCUM, 8'(i % 4), 8'(i % 3), $urandom);
        no_gaps = 0;
    endtask

    // random words over a series of register settings
    task automatic test_random();
        int sizes[8] = '{8, 40, 3, 256, 1, 16, 300, 64};
        int n, p, lim;
        logic [2:0] c;
        logic [7:0] r, k;
        logic signed [31:0] v;
        foreach (sizes[s])
        begin
            write_size(9'(sizes[s]));
            n = (sizes[s] > NCOLS) ? NCOLS : sizes[s];
            // small sizes keep columns dense; the largest sizes see fewer words
            lim = (n >= 64) ? 80 : 170;
            no_gaps = (s == 2);
            for (int i = 0; i < lim; i++)
            begin
                p = $urandom_range(0, 99);
                if (p < 42) c = CMD_ACCUM;
                else if (p < 67) c = CMD_READ;
                else if (p < 84) c = CMD_RESERVE;
                else if (p < 87) c = CMD_ZERO;
                else if (p < 92) c = CMD_SCALE;
                else if (p < 94) c = CMD_CLEAR;
                else if (p < 97) c = CMD_UNDEF_A;
                else c = CMD_UNDEF_B;
                if ($urandom_range(0, 9) == 0)
                begin
                    r = $urandom;
                    k = $urandom;
                end
                else
                begin
                    r = $urandom_range(0, n - 1);
                    k = (n > 6) ? $urandom_range(0, 5) : $urandom_range(0, n - 1);
                end
                p = $urandom_range(0, 9);
                if (c == CMD_SCALE)
                    v = (p < 7) ? 32'sh10000 + $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000
                                : $urandom;
                else if (p < 6)
                    v = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
                else
                    v = $urandom;
                send_word(c, r, k, v);
            end
        end
        no_gaps = 0;
    endtask

    // result receiver with random stalls
    initial
    begin
        int p;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            p = $urandom_range(0, 199);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                hold_req = 0;
                repeat (300) @(posedge clk);
            end
            else if (!no_gaps && p == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
            else
                out_ready <= no_gaps || (p < 150);
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        result_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            words_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: value %h slot %0d found %0d status %0d",
                             result_value, slot, found, status);
            end
            else
            begin
                e = pending_results.pop_front();
                if (result_value !== e.res || slot !== e.pos || found !== e.hit
                    || status !== e.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                                 words_checked, e.res, e.pos, e.hit, e.st,
                                 result_value, slot, found, status);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("[sparse_column_accumulate_store_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        size_reg = 256;
        for (int i = 0; i < NCOLS; i++) col_fill[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_range();
        test_column_full();
        test_backpressure();
        test_random();
        @(posedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d words over size settings 0..511, bulk commands, full columns,",
                 words_sent);
        $display("saturation, unknown codes and a long output stall; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("[sparse_column_accumulate_store_core] OK");
        else
            $display("[sparse_column_accumulate_store_core] ERROR");
        $finish;
    end

endmodule
